FILE: hw/rtl/ufr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ufr_pkg
// Shared widths, limits and the result record of the disjoint-set table.
// ----------------------------------------------------------------------------
package ufr_pkg;

    localparam int ID_W             = 10;
    localparam int COUNT_W          = 11;
    localparam int RANK_W           = 4;
    localparam int WRAP_KW          = 4;
    localparam int NUM_ELEMENTS_DEF = 1024;
    localparam int S_TDATA_W        = 24;
    localparam int M_TDATA_W        = 16;

    localparam logic [RANK_W-1:0] RANK_MAX = 4'd15;

    typedef struct packed {
        logic               valid;
        logic               different_sets;
        logic [COUNT_W-1:0] set_count;
    } t_res;

    // Number of shifted-divisor subtractions that bring a raw id below n
    function automatic int wrap_steps(input int n);
        int s;
        s = 0;
        for (int k = 0; k < ID_W; k++) begin
            if ((n << k) < (1 << ID_W)) begin
                s = k + 1;
            end
        end
        return s;
    endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/ufr_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ufr_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module ufr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

FILE: hw/rtl/ufr_seq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ufr_seq
// Sequencer: clearing pass, id wrap, two root walks, creation and link writes.
// ----------------------------------------------------------------------------
module ufr_seq #(
    parameter int NUM_ELEMENTS = ufr_pkg::NUM_ELEMENTS_DEF
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_rst_n,
    input  wire logic                                    i_start,
    input  wire logic                                    i_func,
    input  wire logic [ufr_pkg::ID_W-1:0]                i_id_a,
    input  wire logic [ufr_pkg::ID_W-1:0]                i_id_b,
    output logic                                         o_ready,
    output ufr_pkg::t_res                                o_res,
    input  wire logic                                    i_res_ready,
    output logic                                         o_mem_we,
    output logic [$clog2(NUM_ELEMENTS)-1:0]              o_mem_waddr,
    output logic [ufr_pkg::RANK_W+$clog2(NUM_ELEMENTS):0] o_mem_wdata,
    output logic [$clog2(NUM_ELEMENTS)-1:0]              o_mem_raddr,
    input  wire logic [ufr_pkg::RANK_W+$clog2(NUM_ELEMENTS):0] i_mem_rdata
);

    import ufr_pkg::*;

    localparam int IDX_W      = $clog2(NUM_ELEMENTS);
    localparam int ENTRY_W    = 1 + RANK_W + IDX_W;
    localparam int WRAP_STEPS = wrap_steps(NUM_ELEMENTS);

    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_WRAP   = 4'd2;
    localparam logic [3:0] S_RD_A   = 4'd3;
    localparam logic [3:0] S_WALK_A = 4'd4;
    localparam logic [3:0] S_RD_B   = 4'd5;
    localparam logic [3:0] S_WALK_B = 4'd6;
    localparam logic [3:0] S_LINK1  = 4'd7;
    localparam logic [3:0] S_LINK2  = 4'd8;
    localparam logic [3:0] S_FINISH = 4'd9;

    logic [3:0]         r_state, n_state;
    logic [IDX_W-1:0]   r_clr, n_clr;
    logic               r_func, n_func;
    logic [ID_W-1:0]    r_id_a, n_id_a;
    logic [ID_W-1:0]    r_id_b, n_id_b;
    logic [WRAP_KW-1:0] r_k, n_k;
    logic [IDX_W-1:0]   r_cur, n_cur;
    logic [IDX_W-1:0]   r_root_a, n_root_a;
    logic [IDX_W-1:0]   r_root_b, n_root_b;
    logic [RANK_W-1:0]  r_rank_a, n_rank_a;
    logic [RANK_W-1:0]  r_rank_b, n_rank_b;
    logic               r_differ, n_differ;
    logic [COUNT_W-1:0] r_count, n_count;

    logic [ID_W:0]      w_div;
    logic               w_present;
    logic [IDX_W-1:0]   w_parent;
    logic [RANK_W-1:0]  w_rank;
    logic               w_is_root;

    assign w_div     = (ID_W+1)'(NUM_ELEMENTS << r_k);
    assign w_present = i_mem_rdata[ENTRY_W-1];
    assign w_parent  = i_mem_rdata[IDX_W-1:0];
    assign w_rank    = w_present ? i_mem_rdata[IDX_W +: RANK_W] : '0;
    // an absent id is its own root
    assign w_is_root = !w_present || (w_parent == r_cur);

    assign o_ready            = (r_state == S_IDLE);
    assign o_res.valid        = (r_state == S_FINISH);
    assign o_res.different_sets = r_differ;
    assign o_res.set_count    = r_count;

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_func      = r_func;
        n_id_a      = r_id_a;
        n_id_b      = r_id_b;
        n_k         = r_k;
        n_cur       = r_cur;
        n_root_a    = r_root_a;
        n_root_b    = r_root_b;
        n_rank_a    = r_rank_a;
        n_rank_b    = r_rank_b;
        n_differ    = r_differ;
        n_count     = r_count;
        o_mem_we    = 1'b0;
        o_mem_waddr = r_cur;
        o_mem_wdata = {1'b1, {RANK_W{1'b0}}, r_cur};
        o_mem_raddr = r_cur;

        case (r_state)
            S_CLEAR: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_clr;
                o_mem_wdata = '0;
                n_clr       = r_clr + 1'b1;
                if (r_clr == IDX_W'(NUM_ELEMENTS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    n_func = i_func;
                    n_id_a = i_id_a;
                    n_id_b = i_id_b;
                    n_k    = WRAP_KW'(WRAP_STEPS - 1);
                    if (WRAP_STEPS == 0) begin
                        n_state = S_RD_A;
                    end else begin
                        n_state = S_WRAP;
                    end
                end
            end
            S_WRAP: begin
                // one restoring step of id modulo the table size, for both ids
                if ({1'b0, r_id_a} >= w_div) begin
                    n_id_a = r_id_a - w_div[ID_W-1:0];
                end
                if ({1'b0, r_id_b} >= w_div) begin
                    n_id_b = r_id_b - w_div[ID_W-1:0];
                end
                n_k = r_k - 1'b1;
                if (r_k == '0) begin
                    n_state = S_RD_A;
                end
            end
            S_RD_A: begin
                o_mem_raddr = IDX_W'(r_id_a);
                n_cur       = IDX_W'(r_id_a);
                n_state     = S_WALK_A;
            end
            S_WALK_A: begin
                if (w_is_root) begin
                    n_root_a = r_cur;
                    n_rank_a = w_rank;
                    if (!w_present && !r_func) begin
                        o_mem_we = 1'b1;
                        n_count  = r_count + 1'b1;
                    end
                    n_state = S_RD_B;
                end else begin
                    o_mem_raddr = w_parent;
                    n_cur       = w_parent;
                end
            end
            S_RD_B: begin
                // issued after any creation write of id_a has reached the table, so an equal id sees it
                o_mem_raddr = IDX_W'(r_id_b);
                n_cur       = IDX_W'(r_id_b);
                n_state     = S_WALK_B;
            end
            S_WALK_B: begin
                if (w_is_root) begin
                    n_root_b = r_cur;
                    n_rank_b = w_rank;
                    n_differ = (r_cur != r_root_a);
                    if (!w_present && !r_func) begin
                        o_mem_we = 1'b1;
                        n_count  = r_count + 1'b1;
                    end
                    if (!r_func && (r_cur != r_root_a)) begin
                        n_state = S_LINK1;
                    end else begin
                        n_state = S_FINISH;
                    end
                end else begin
                    o_mem_raddr = w_parent;
                    n_cur       = w_parent;
                end
            end
            S_LINK1: begin
                o_mem_we = 1'b1;
                n_count  = r_count - 1'b1;
                if (r_rank_a >= r_rank_b) begin
                    o_mem_waddr = r_root_b;
                    o_mem_wdata = {1'b1, r_rank_b, r_root_a};
                    if ((r_rank_a == r_rank_b) && (r_rank_a != RANK_MAX)) begin
                        n_state = S_LINK2;
                    end else begin
                        n_state = S_FINISH;
                    end
                end else begin
                    o_mem_waddr = r_root_a;
                    o_mem_wdata = {1'b1, r_rank_a, r_root_b};
                    n_state     = S_FINISH;
                end
            end
            S_LINK2: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_root_a;
                o_mem_wdata = {1'b1, r_rank_a + 1'b1, r_root_a};
                n_state     = S_FINISH;
            end
            S_FINISH: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func   <= n_func;
        r_id_a   <= n_id_a;
        r_id_b   <= n_id_b;
        r_k      <= n_k;
        r_cur    <= n_cur;
        r_root_a <= n_root_a;
        r_root_b <= n_root_b;
        r_rank_a <= n_rank_a;
        r_rank_b <= n_rank_b;
        r_differ <= n_differ;
    end

endmodule
`default_nettype wire

FILE: hw/rtl/union_find_by_rank.sv
`default_nettype none
// ----------------------------------------------------------------------------
// union_find_by_rank
// Disjoint-set table with union by rank, held in one single-port-read RAM.
// ----------------------------------------------------------------------------
// Input stream (s side): tuser carries func (0 union, 1 query), tdata carries
// id_a in bits [9:0] and id_b in bits [19:10]. Each transfer yields one
// result transfer on the m side: tdata bit 0 different_sets, bits [11:1] the
// set count after the item.
// After reset a clearing pass writes every table entry, with s_tready low;
// nothing else is reset but the count and the control.
// An item passes through W wrap steps (zero when NUM_ELEMENTS is a power of two
// of 1024 or more), root walks over Da and Db parent links from each id (at
// most log2 NUM_ELEMENTS each) and L link writes, one or two on a merging
// union, else zero. One item is in work at a time; the next is taken only
// once the result has moved to the output register. The root walks issue
// one RAM read a cycle.
// The output register holds a result while i_m_tready is low; one further
// item may be accepted and worked meanwhile, then waits in its final state.
// ----------------------------------------------------------------------------
module union_find_by_rank #(
    parameter int NUM_ELEMENTS = ufr_pkg::NUM_ELEMENTS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_s_tvalid,
    output logic                               o_s_tready,
    input  wire logic [ufr_pkg::S_TDATA_W-1:0] i_s_tdata,  // id_a, id_b, zero pad
    input  wire logic                          i_s_tuser,  // func
    output logic                               o_m_tvalid,
    input  wire logic                          i_m_tready,
    output logic      [ufr_pkg::M_TDATA_W-1:0] o_m_tdata   // different_sets, set_count, pad
);

    import ufr_pkg::*;

    localparam int IDX_W   = $clog2(NUM_ELEMENTS);
    localparam int ENTRY_W = 1 + RANK_W + IDX_W;

    t_res               w_res;
    logic               w_res_ready;
    logic               w_mem_we;
    logic [IDX_W-1:0]   w_mem_waddr;
    logic [ENTRY_W-1:0] w_mem_wdata;
    logic [IDX_W-1:0]   w_mem_raddr;
    logic [ENTRY_W-1:0] w_mem_rdata;

    logic               r_m_valid;
    logic               r_m_diff;
    logic [COUNT_W-1:0] r_m_count;

    ufr_seq #(
        .NUM_ELEMENTS(NUM_ELEMENTS)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_s_tvalid && o_s_tready),
        .i_func      (i_s_tuser),
        .i_id_a      (i_s_tdata[ID_W-1:0]),
        .i_id_b      (i_s_tdata[2*ID_W-1:ID_W]),
        .o_ready     (o_s_tready),
        .o_res       (w_res),
        .i_res_ready (w_res_ready),
        .o_mem_we    (w_mem_we),
        .o_mem_waddr (w_mem_waddr),
        .o_mem_wdata (w_mem_wdata),
        .o_mem_raddr (w_mem_raddr),
        .i_mem_rdata (w_mem_rdata)
    );

    ufr_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(NUM_ELEMENTS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_raddr (w_mem_raddr),
        .o_rdata (w_mem_rdata)
    );

    assign w_res_ready = !r_m_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_res.valid && w_res_ready) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res.valid && w_res_ready) begin
            r_m_diff  <= w_res.different_sets;
            r_m_count <= w_res.set_count;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {{(M_TDATA_W-COUNT_W-1){1'b0}}, r_m_count, r_m_diff};

    // the clearing pass follows every reset, so no input is taken straight after
    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_s_tready)
        else $error("input accepted during the clearing pass");

    // the sequencer takes no item while it still offers a result
    a_no_accept_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_s_tready && w_res.valid))
        else $error("sequencer ready while holding a result");

    // a result the output register cannot take is held unchanged
    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_res.valid && !w_res_ready) |=> (w_res.valid && $stable(w_res)))
        else $error("pending result dropped or changed");

endmodule
`default_nettype wire
